// ===== rtl/core/fpr_pkg.sv =====
package fpr_pkg;

	// field and register widths
	localparam int PAGE_W       = 5;
	localparam int FRAME_W      = 4;
	localparam int NUM_PAGES_W  = 6;
	localparam int NUM_FRAMES_W = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_PAGES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES = 2'd1;

	// register reset values
	localparam logic [NUM_PAGES_W-1:0]  NUM_PAGES_RST  = 6'd5;
	localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RST = 5'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic rd_en;
		logic commit;
	} cmd_t;

endpackage

// ===== rtl/core/fifo_page_replacement_top.sv =====
// FIFO page replacement unit. Each input word is one virtual page reference; each one
// gives exactly one result word: hit, the frame now holding the page, the evicted page
// if any, or bad_page alone when the page is not below num_pages (nothing changes then).
// A miss takes the lowest free frame below num_frames, otherwise the resident page with
// the largest age (lowest page on a tie) is evicted and its frame reused. The oldest page
// is found by a registered compare tree of clog2(MAX_PAGES) levels over all pages. A
// reference goes through an accept step, the tree settling, a frame-table read and a
// commit, which waits while the previous result is still held and not taken; its result
// is registered at the commit.
// Only one reference is in flight, the result register lets the next one be taken while
// a result waits. Configuration writes are always ready and are meant for idle periods.
module fifo_page_replacement_top #(
	parameter int MAX_PAGES  = 32,
	parameter int MAX_FRAMES = 16,
	parameter int AGE_WIDTH  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fpr_pkg::PAGE_W-1:0]     page_number,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [fpr_pkg::FRAME_W-1:0]    frame_index,
	output logic                           evicted_valid,
	output logic [fpr_pkg::PAGE_W-1:0]     evicted_page,
	output logic                           bad_page
);
	import fpr_pkg::*;

	localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	// sequencer
	fpr_ctrl #(
		.SCAN_CYCLES(PW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// tables, age tree and result register
	fpr_datapath #(
		.MAX_PAGES (MAX_PAGES),
		.MAX_FRAMES(MAX_FRAMES),
		.AGE_WIDTH (AGE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.page_number  (page_number),
		.cmd          (cmd),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.bad_page     (bad_page)
	);

endmodule

// ===== rtl/core/fpr_ctrl.sv =====
module fpr_ctrl #(
	parameter int SCAN_CYCLES = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output fpr_pkg::cmd_t cmd
);
	import fpr_pkg::*;

	localparam int CW = $clog2(SCAN_CYCLES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_COMMIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free;

	// decode of state into handshake and commands
	assign in_ready    = (state_q == S_IDLE);
	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.rd_en   = (state_q == S_READ);
	assign cmd.commit  = (state_q == S_COMMIT) && out_free;

	// sequencer and output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// let the age tree settle to its root
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(SCAN_CYCLES - 1)) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit while the output word is still held");

	a_no_commit_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.commit)
		else $error("commit while idle");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word taken while one is in flight");

endmodule

// ===== rtl/core/fpr_datapath.sv =====
module fpr_datapath #(
	parameter int MAX_PAGES  = 32,
	parameter int MAX_FRAMES = 16,
	parameter int AGE_WIDTH  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [fpr_pkg::PAGE_W-1:0]         page_number,
	input  fpr_pkg::cmd_t                      cmd,
	output logic                               hit,
	output logic [fpr_pkg::FRAME_W-1:0]        frame_index,
	output logic                               evicted_valid,
	output logic [fpr_pkg::PAGE_W-1:0]         evicted_page,
	output logic                               bad_page
);
	import fpr_pkg::*;

	localparam int PW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int FW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int LEAVES = 1 << PW;
	localparam int NODES  = LEAVES - 1;
	localparam logic [7:0] MAXP8 = 8'(MAX_PAGES);
	localparam logic [7:0] MAXF8 = 8'(MAX_FRAMES);

	typedef struct packed {
		logic                 have;
		logic [AGE_WIDTH-1:0] age;
		logic [PW-1:0]        idx;
	} cand_t;

	// configuration registers
	logic [NUM_PAGES_W-1:0]  num_pages_q;
	logic [NUM_FRAMES_W-1:0] num_frames_q;

	// page and frame tables
	logic                 resident_q [MAX_PAGES];
	logic [AGE_WIDTH-1:0] age_q      [MAX_PAGES];
	logic [FW-1:0]        pf_mem     [MAX_PAGES];
	logic [FW-1:0]        pf_rd_q;
	logic [MAX_FRAMES-1:0] frame_used_q;

	// current word and max-age tree
	logic [PAGE_W-1:0]    pg_q;
	logic [PW+PAGE_W-1:0] pg_ext;
	logic [PW-1:0]        pg_idx;
	cand_t                leaf   [MAX_PAGES];
	cand_t                node_d [NODES];
	cand_t                node_q [NODES];
	cand_t                root;

	logic [7:0]    np_w, nf_w, np_c, nf_c;
	logic          bad_c, hit_c, free_found, load, evict;
	logic [FW-1:0] free_idx, frame_c;
	logic [PW-1:0] rd_addr;
	logic          res_d [MAX_PAGES];
	logic [AGE_WIDTH-1:0] base_d [MAX_PAGES];
	logic [FW+FRAME_W-1:0] frame_ext;
	logic [PW+PAGE_W-1:0]  ev_ext;

	// configuration writes, port is always ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_pages_q  <= NUM_PAGES_RST;
			num_frames_q <= NUM_FRAMES_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_NUM_PAGES) begin
				num_pages_q <= cfg_data[NUM_PAGES_W-1:0];
			end else if (cfg_index == REG_NUM_FRAMES) begin
				num_frames_q <= cfg_data[NUM_FRAMES_W-1:0];
			end
		end
	end

	// saturate registers into their legal ranges
	always_comb begin
		np_w = {{(8-NUM_PAGES_W){1'b0}}, num_pages_q};
		nf_w = {{(8-NUM_FRAMES_W){1'b0}}, num_frames_q};
		if (np_w == 8'd0) np_c = 8'd1;
		else if (np_w > MAXP8) np_c = MAXP8;
		else np_c = np_w;
		if (nf_w == 8'd0) nf_c = 8'd1;
		else if (nf_w > MAXF8) nf_c = MAXF8;
		else nf_c = nf_w;
	end

	// page index of the word in flight
	assign pg_ext = {{PW{1'b0}}, pg_q};
	assign pg_idx = pg_ext[PW-1:0];
	assign bad_c  = {{(8-PAGE_W){1'b0}}, pg_q} >= np_c;
	assign hit_c  = resident_q[pg_idx];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pg_q <= page_number;
		end
	end

	// leaves of the age tree
	always_comb begin
		for (int i = 0; i < MAX_PAGES; i++) begin
			leaf[i].have = resident_q[i];
			leaf[i].age  = age_q[i];
			leaf[i].idx  = PW'(i);
		end
	end

	// one registered compare per node, older wins, left wins a tie
	always_comb begin
		int    c;
		cand_t pair [2];
		for (int n = 0; n < NODES; n++) begin
			for (int s = 0; s < 2; s++) begin
				c = 2 * n + 1 + s;
				if (c < NODES) pair[s] = node_q[c];
				else if (c - NODES < MAX_PAGES) pair[s] = leaf[c - NODES];
				else pair[s] = '0;
			end
			if (pair[0].have && (!pair[1].have || pair[0].age >= pair[1].age)) begin
				node_d[n] = pair[0];
			end else begin
				node_d[n] = pair[1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < NODES; n++) begin
			node_q[n] <= node_d[n];
		end
	end

	assign root = node_q[0];

	// lowest free frame below the frame count
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int f = MAX_FRAMES - 1; f >= 0; f--) begin
			if (!frame_used_q[f] && (8'(f) < nf_c)) begin
				free_found = 1'b1;
				free_idx   = FW'(f);
			end
		end
	end

	// frame table read: own frame on a hit, victim frame otherwise
	assign rd_addr = hit_c ? pg_idx : root.idx;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			pf_rd_q <= pf_mem[rd_addr];
		end
		if (cmd.commit && !bad_c && load) begin
			pf_mem[pg_idx] <= frame_c;
		end
	end

	// placement decision
	always_comb begin
		load    = 1'b0;
		evict   = 1'b0;
		frame_c = '0;
		priority if (hit_c) begin
			frame_c = pf_rd_q;
		end else if (free_found) begin
			load    = 1'b1;
			frame_c = free_idx;
		end else if (root.have) begin
			load    = 1'b1;
			evict   = 1'b1;
			frame_c = pf_rd_q;
		end
	end

	// next residency and age before the aging step
	always_comb begin
		for (int p = 0; p < MAX_PAGES; p++) begin
			res_d[p]  = resident_q[p];
			base_d[p] = age_q[p];
			if (evict && (root.idx == PW'(p))) begin
				res_d[p]  = 1'b0;
				base_d[p] = '0;
			end
			if (load && (pg_idx == PW'(p))) begin
				res_d[p]  = 1'b1;
				base_d[p] = '0;
			end
		end
	end

	// table update, every resident page ages by one and saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_used_q <= '0;
			for (int p = 0; p < MAX_PAGES; p++) begin
				resident_q[p] <= 1'b0;
				age_q[p]      <= '0;
			end
		end else if (cmd.commit && !bad_c) begin
			if (load) begin
				frame_used_q[frame_c] <= 1'b1;
			end
			for (int p = 0; p < MAX_PAGES; p++) begin
				resident_q[p] <= res_d[p];
				if (res_d[p] && (base_d[p] != {AGE_WIDTH{1'b1}})) begin
					age_q[p] <= base_d[p] + 1'b1;
				end else begin
					age_q[p] <= base_d[p];
				end
			end
		end
	end

	// result word
	assign frame_ext = {{FRAME_W{1'b0}}, frame_c};
	assign ev_ext    = {{PAGE_W{1'b0}}, root.idx};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			bad_page      <= bad_c;
			hit           <= !bad_c && hit_c;
			frame_index   <= bad_c ? '0 : frame_ext[FRAME_W-1:0];
			evicted_valid <= !bad_c && evict;
			evicted_page  <= (!bad_c && evict) ? ev_ext[PAGE_W-1:0] : '0;
		end
	end

	a_frames_stay_used: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_used_q & $past(frame_used_q)) == $past(frame_used_q))
		else $error("a used frame was released");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && evict) |-> root.have)
		else $error("eviction with no resident page");

	a_hit_not_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && hit_c) |-> !load)
		else $error("resident page loaded again");

endmodule
